/* rtl/core/gauss_jordan_linear_solver_top_defines.svh */
// Assertion macros used by the solver checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef GAUSS_JORDAN_LINEAR_SOLVER_TOP_DEFINES_SVH
`define GAUSS_JORDAN_LINEAR_SOLVER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GJLS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("solver check failed");

// Consequent must hold in the cycle after the antecedent.
`define GJLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("solver check failed");

`endif

/* rtl/core/gjls_pkg.sv */
`timescale 1ns / 1ps

package gjls_pkg;

    // Default matrix size, ground row included.
    localparam int DEFAULT_MAX_NODES = 16;

    // Row and column fields wide enough for the largest supported matrix.
    localparam int ROW_W = 6;
    localparam int COL_W = 7;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam logic REG_IDX_NODES = 1'b0;
    localparam logic REG_IDX_TOL   = 1'b1;
    localparam logic [4:0]  NODES_RESET = 5'd16;
    localparam logic [30:0] TOL_RESET   = 31'd1;

    // Request opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [3:0]         row_index;
        logic [4:0]         column_index;
        logic signed [31:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         node_number;
        logic signed [31:0] node_value;
        logic               singular;
        logic               last;
    } out_item_t;

    // Source of the data written into the matrix store.
    typedef enum logic [2:0] {
        WR_ENTRY,
        WR_QUOT,
        WR_TMP,
        WR_RDATA,
        WR_DIFF
    } wr_sel_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic [COL_W-1:0] rd_col;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        wr_sel_t          wr_sel;
        logic             best_clr;
        logic             best_cap;
        logic             tmp_cap;
        logic             div_start;
        logic             prod_cap;
        logic             mq_cap;
        logic             out_load;
        logic             out_singular;
        logic             out_last;
        logic [3:0]       out_node;
    } cmd_t;

    typedef struct packed {
        logic better;
        logic below_tol;
        logic div_done;
        logic entry_ok;
    } status_t;

    // Magnitude of a Q16.16 word; the most negative value maps to 2^31.
    function automatic logic [31:0] q_mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Product scaled back by 2^16, rounding toward zero, then saturated.
    function automatic logic signed [31:0] q_scale(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p[63] ? ((p + 64'sd65535) >>> 16) : (p >>> 16);
        if (t > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (t < -64'sd2147483648)
            return 32'sh80000000;
        else
            return t[31:0];
    endfunction

    // Saturating subtract.
    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (d < -33'sd2147483648)
            return 32'sh80000000;
        else
            return d[31:0];
    endfunction

endpackage

/* rtl/core/gjls_ram.sv */
`timescale 1ns / 1ps

module gjls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 272,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/gjls_div.sv */
`timescale 1ns / 1ps

module gjls_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [31:0] q
);
    import gjls_pkg::*;

    localparam int QB = 48;

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic              neg_reg;
    logic [31:0]       rem_reg;
    logic [QB-1:0]     dvd_reg;
    logic [31:0]       dvs_reg;
    logic signed [31:0] q_reg;

    logic [32:0]       shifted;
    logic              ge;
    logic [31:0]       rem_step;
    logic signed [31:0] q_zero_div;
    logic signed [31:0] q_final;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[QB-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_step = ge ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
    end

    // Division by zero saturates by the sign of the dividend.
    always_comb
    begin
        if (a == 32'sd0)
            q_zero_div = 32'sd0;
        else if (a[31])
            q_zero_div = 32'sh80000000;
        else
            q_zero_div = 32'sh7FFFFFFF;
    end

    // Apply the sign to the quotient magnitude and saturate.
    always_comb
    begin
        if (neg_reg)
        begin
            if (dvd_reg > 48'h0000_8000_0000)
                q_final = 32'sh80000000;
            else
                q_final = ~dvd_reg[31:0] + 32'd1;
        end
        else
        begin
            if (dvd_reg > 48'h0000_7FFF_FFFF)
                q_final = 32'sh7FFFFFFF;
            else
                q_final = dvd_reg[31:0];
        end
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg  <= busy_reg && (cnt_reg == 6'd0);
            done_reg <= (start && (b == 32'sd0)) || fin_reg;
            if (start && (b != 32'sd0))
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(QB - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // Operands, partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[31] ^ b[31];
            dvd_reg <= {q_mag(a), 16'd0};
            dvs_reg <= q_mag(b);
            rem_reg <= '0;
            if (b == 32'sd0)
                q_reg <= q_zero_div;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[QB-2:0], ge};
        end
        if (fin_reg)
        begin
            q_reg <= q_final;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

/* rtl/core/gjls_datapath.sv */
`timescale 1ns / 1ps

module gjls_datapath #(
    parameter int MAX_NODES = gjls_pkg::DEFAULT_MAX_NODES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gjls_pkg::cmd_t      cmd,
    input  gjls_pkg::in_item_t  in_data,
    input  logic [30:0]         tol,
    output gjls_pkg::status_t   status,
    output gjls_pkg::out_item_t out_data
);
    import gjls_pkg::*;

    localparam int COLS  = MAX_NODES + 1;
    localparam int DEPTH = MAX_NODES * COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic signed [31:0] rd_data;
    logic signed [31:0] div_q;
    logic               div_done;

    logic signed [31:0] best_reg;
    logic signed [31:0] tmp_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mq_reg;
    out_item_t          out_reg;

    // Row-major addressing of the augmented matrix.
    always_comb
    begin
        rd_addr = AW'(cmd.rd_row) * AW'(COLS) + AW'(cmd.rd_col);
        if (cmd.wr_sel == WR_ENTRY)
            wr_addr = AW'(in_data.row_index) * AW'(COLS) + AW'(in_data.column_index);
        else
            wr_addr = AW'(cmd.wr_row) * AW'(COLS) + AW'(cmd.wr_col);
    end

    // Write data selection.
    always_comb
    begin
        case (cmd.wr_sel)
            WR_ENTRY: wr_data = in_data.entry_value;
            WR_QUOT:  wr_data = div_q;
            WR_TMP:   wr_data = tmp_reg;
            WR_RDATA: wr_data = rd_data;
            WR_DIFF:  wr_data = q_sub(tmp_reg, mq_reg);
            default:  wr_data = rd_data;
        endcase
    end

    gjls_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    gjls_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .a    (rd_data),
        .b    (best_reg),
        .done (div_done),
        .q    (div_q)
    );

    // Status toward the controller.
    always_comb
    begin
        status.better    = q_mag(rd_data) > q_mag(best_reg);
        status.below_tol = q_mag(best_reg) < {1'b0, tol};
        status.div_done  = div_done;
        status.entry_ok  = (in_data.row_index != 4'd0)
                        && (32'(in_data.row_index) < MAX_NODES)
                        && (in_data.column_index != 5'd0)
                        && (32'(in_data.column_index) <= MAX_NODES);
    end

    // Working registers: pivot, operand hold, product, scaled product and output result.
    always_ff @(posedge clk)
    begin
        if (cmd.best_clr)
            best_reg <= 32'sd0;
        else if (cmd.best_cap && status.better)
            best_reg <= rd_data;
        if (cmd.tmp_cap)
            tmp_reg <= rd_data;
        if (cmd.prod_cap)
            prod_reg <= 64'(rd_data) * 64'(div_q);
        if (cmd.mq_cap)
            mq_reg <= q_scale(prod_reg);
        if (cmd.out_load)
        begin
            out_reg.node_number <= cmd.out_node;
            out_reg.node_value  <= cmd.out_singular ? 32'sd0 : rd_data;
            out_reg.singular    <= cmd.out_singular;
            out_reg.last        <= cmd.out_last;
        end
    end

    assign out_data = out_reg;

endmodule

/* rtl/core/gjls_ctrl.sv */
`timescale 1ns / 1ps

module gjls_ctrl #(
    parameter int MAX_NODES = gjls_pkg::DEFAULT_MAX_NODES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic [4:0]        nodes_in_use,
    input  gjls_pkg::status_t status,
    output gjls_pkg::cmd_t    cmd
);
    import gjls_pkg::*;

    localparam int RW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [RW-1:0] ONE_R = RW'(1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SRCH_INIT,
        S_SRCH_RD,
        S_SRCH_CAP,
        S_SWAP_CHK,
        S_SW_RD_A,
        S_SW_RD_B,
        S_SW_WR_A,
        S_SW_WR_B,
        S_PIV_CHK,
        S_DIV_RD,
        S_DIV_START,
        S_DIV_WAIT,
        S_DIV_WR,
        S_ROW_CHK,
        S_ROW_RD_A,
        S_ROW_RD_B,
        S_ROW_SUB,
        S_ROW_WR,
        S_COL_NEXT,
        S_OUT_RD,
        S_OUT_LOAD
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [RW-1:0] i_reg, i_next;
    logic [RW-1:0] at_reg, at_next;
    logic [CW-1:0] l_reg, l_next;
    logic [CW-1:0] j_reg, j_next;
    logic          sing_reg, sing_next;
    logic          in_stall_reg, in_stall_next;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic          out_free;
    logic          i_is_last;
    logic [CW-1:0] n_clamp;

    assign accept    = in_valid && !in_stall_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign i_is_last = CW'(i_reg) == (n_reg - ONE_C);
    assign n_clamp   = (nodes_in_use < 5'd2) ? CW'(2)
                     : (32'(nodes_in_use) > MAX_NODES) ? CW'(MAX_NODES)
                     : CW'(nodes_in_use);

    // Sequencer for entry writes, search, swap, normalize/eliminate and result readout.
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        at_next    = at_reg;
        l_next     = l_reg;
        j_next     = j_reg;
        sing_next  = sing_reg;
        cmd        = '0;
        cmd.wr_sel = WR_ENTRY;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_WRITE)
                    begin
                        cmd.wr_en = status.entry_ok;
                    end
                    else
                    begin
                        n_next     = n_clamp;
                        i_next     = ONE_R;
                        sing_next  = 1'b0;
                        state_next = S_SRCH_INIT;
                    end
                end
            end
            S_SRCH_INIT:
            begin
                cmd.best_clr = 1'b1;
                at_next      = i_reg;
                l_next       = CW'(i_reg);
                state_next   = S_SRCH_RD;
            end
            S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = ROW_W'(l_reg);
                cmd.rd_col = COL_W'(i_reg);
                state_next = S_SRCH_CAP;
            end
            S_SRCH_CAP:
            begin
                cmd.best_cap = 1'b1;
                if (status.better)
                    at_next = RW'(l_reg);
                if (l_reg == n_reg - ONE_C)
                    state_next = S_SWAP_CHK;
                else
                begin
                    l_next     = l_reg + ONE_C;
                    state_next = S_SRCH_RD;
                end
            end
            S_SWAP_CHK:
            begin
                if (at_reg != i_reg)
                begin
                    l_next     = ONE_C;
                    state_next = S_SW_RD_A;
                end
                else
                    state_next = S_PIV_CHK;
            end
            S_SW_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = ROW_W'(i_reg);
                cmd.rd_col = COL_W'(l_reg);
                state_next = S_SW_RD_B;
            end
            S_SW_RD_B:
            begin
                cmd.tmp_cap = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_row  = ROW_W'(at_reg);
                cmd.rd_col  = COL_W'(l_reg);
                state_next  = S_SW_WR_A;
            end
            S_SW_WR_A:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_RDATA;
                cmd.wr_row = ROW_W'(i_reg);
                cmd.wr_col = COL_W'(l_reg);
                state_next = S_SW_WR_B;
            end
            S_SW_WR_B:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_TMP;
                cmd.wr_row = ROW_W'(at_reg);
                cmd.wr_col = COL_W'(l_reg);
                if (l_reg == n_reg)
                    state_next = S_PIV_CHK;
                else
                begin
                    l_next     = l_reg + ONE_C;
                    state_next = S_SW_RD_A;
                end
            end
            S_PIV_CHK:
            begin
                if (status.below_tol)
                begin
                    sing_next  = 1'b1;
                    i_next     = ONE_R;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    j_next     = n_reg;
                    state_next = S_DIV_RD;
                end
            end
            S_DIV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = ROW_W'(i_reg);
                cmd.rd_col = COL_W'(j_reg);
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = S_DIV_WR;
            end
            S_DIV_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_QUOT;
                cmd.wr_row = ROW_W'(i_reg);
                cmd.wr_col = COL_W'(j_reg);
                l_next     = ONE_C;
                state_next = S_ROW_CHK;
            end
            S_ROW_CHK:
            begin
                if (l_reg == n_reg)
                    state_next = S_COL_NEXT;
                else if (l_reg == CW'(i_reg))
                    l_next = l_reg + ONE_C;
                else
                    state_next = S_ROW_RD_A;
            end
            S_ROW_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = ROW_W'(l_reg);
                cmd.rd_col = COL_W'(i_reg);
                state_next = S_ROW_RD_B;
            end
            S_ROW_RD_B:
            begin
                cmd.prod_cap = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_row   = ROW_W'(l_reg);
                cmd.rd_col   = COL_W'(j_reg);
                state_next   = S_ROW_SUB;
            end
            S_ROW_SUB:
            begin
                cmd.tmp_cap = 1'b1;
                cmd.mq_cap  = 1'b1;
                state_next  = S_ROW_WR;
            end
            S_ROW_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DIFF;
                cmd.wr_row = ROW_W'(l_reg);
                cmd.wr_col = COL_W'(j_reg);
                l_next     = l_reg + ONE_C;
                state_next = S_ROW_CHK;
            end
            S_COL_NEXT:
            begin
                if (j_reg == ONE_C)
                begin
                    if (i_is_last)
                    begin
                        i_next     = ONE_R;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + ONE_R;
                        state_next = S_SRCH_INIT;
                    end
                end
                else
                begin
                    j_next     = j_reg - ONE_C;
                    state_next = S_DIV_RD;
                end
            end
            S_OUT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = ROW_W'(i_reg);
                cmd.rd_col = COL_W'(n_reg);
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD:
            begin
                if (out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_singular = sing_reg;
                    cmd.out_last     = i_is_last;
                    cmd.out_node     = 4'(i_reg);
                    if (i_is_last)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + ONE_R;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Registered handshake outputs.
    always_comb
    begin
        in_stall_next = state_next != S_IDLE;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            at_reg        <= '0;
            l_reg         <= '0;
            j_reg         <= '0;
            sing_reg      <= 1'b0;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            at_reg        <= at_next;
            l_reg         <= l_next;
            j_reg         <= j_next;
            sing_reg      <= sing_next;
            in_stall_reg  <= in_stall_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/gauss_jordan_linear_solver_top.sv */
`timescale 1ns / 1ps
// Gauss-Jordan solver for a nodal system in signed Q16.16.
// Input channel (in_valid/in_stall/in_data): a write request stores one in-range
// matrix entry and does not stall the input, so writes stream one per cycle while no solve runs.
// A solve request stalls the input until every result has been queued.
// Output channel (out_valid/out_stall/out_data): one result per node 1..n-1,
// the final one marked with last; singular results read zero.
// A solve's running time is set by the single read and write port of the matrix
// store and by the bit-serial divider, which takes 48 steps per normalized entry.
// The output register lets the next request be taken while the last result
// waits; a stalled receiver holds the readout until the register frees.
// Reset clears the controller and sets nodes_in_use to 16 and the tolerance
// to 1; matrix contents are undefined until written.
// Configuration uses an APB-style port; the user must write it only while the block is idle (not enforced).

module gauss_jordan_linear_solver_top #(
    parameter int MAX_NODES = gjls_pkg::DEFAULT_MAX_NODES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  gjls_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output gjls_pkg::out_item_t         out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gjls_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import gjls_pkg::*;

    logic [4:0]  nodes_reg;
    logic [30:0] tol_reg;
    logic        reg_idx;
    cmd_t        cmd;
    status_t     status;

    assign reg_idx = paddr[ADDR_W-1];
    assign pready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg <= NODES_RESET;
            tol_reg   <= TOL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_IDX_NODES: nodes_reg <= pwdata[4:0];
                REG_IDX_TOL:   tol_reg   <= pwdata[30:0];
                default:       nodes_reg <= nodes_reg;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (reg_idx)
            REG_IDX_NODES: prdata = {27'd0, nodes_reg};
            REG_IDX_TOL:   prdata = {1'b0, tol_reg};
            default:       prdata = 32'd0;
        endcase
    end

    gjls_ctrl #(
        .MAX_NODES(MAX_NODES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_op       (in_data.op),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .nodes_in_use(nodes_reg),
        .status      (status),
        .cmd         (cmd)
    );

    gjls_datapath #(
        .MAX_NODES(MAX_NODES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_data (in_data),
        .tol     (tol_reg),
        .status  (status),
        .out_data(out_data)
    );

endmodule

/* rtl/core/gjls_checker.sv */
`timescale 1ns / 1ps
`include "gauss_jordan_linear_solver_top_defines.svh"

module gjls_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input gjls_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input gjls_pkg::out_item_t out_data
);
    import gjls_pkg::*;

    // A stalled result stays presented and unchanged.
    `GJLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // Results of a singular solve read zero.
    `GJLS_ASSERT_SAME(a_sing_zero, out_valid && out_data.singular, out_data.node_value == 32'sd0)

    // An entry write never makes the block busy.
    `GJLS_ASSERT_NEXT(a_write_idle, in_valid && !in_stall && in_data.op == OP_WRITE, !in_stall)

    // A solve request holds off the next request.
    `GJLS_ASSERT_NEXT(a_solve_busy, in_valid && !in_stall && in_data.op == OP_SOLVE, in_stall)

endmodule

bind gauss_jordan_linear_solver_top gjls_checker u_gjls_checker (.*);

/* bench/tb_gauss_jordan_linear_solver_top.sv */
`timescale 1ns / 1ps

module tb_gauss_jordan_linear_solver_top;

    import gjls_pkg::*;

    localparam int NMAX = 16;
    localparam int NCOL = NMAX + 1;
    localparam longint CYCLE_LIMIT = 3000000;

    // One row of the directed stimulus table.
    typedef struct {
        logic        op;
        logic [3:0]  row;
        logic [4:0]  col;
        logic [31:0] val;
        bit          typed;
        logic [31:0] typed_val;
        logic        typed_sing;
    } dir_row_t;

    typedef struct {
        logic [4:0]  nodes;
        logic [30:0] tol;
        int          seqs;
    } phase_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block state.
    logic signed [31:0] shadow_mtx [NMAX][NCOL];
    bit                 entry_written [NMAX][NCOL];
    logic [4:0]         shadow_nodes;
    logic [30:0]        shadow_tol;

    out_item_t solution_q[$];
    int        mismatches;
    int        results_seen;
    bit        quiet;
    longint    cycle_count;

    gauss_jordan_linear_solver_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Q16.16 helpers, rounding toward zero and saturating to 32 bits.
    function automatic logic signed [31:0] fx_sat(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return fx_sat(p / 65536);
    endfunction

    function automatic logic signed [31:0] fx_div(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        if (b == 0)
            return (a > 0) ? 32'sh7FFFFFFF : ((a < 0) ? 32'sh80000000 : 32'sh0);
        return fx_sat((longint'(a) * 65536) / longint'(b));
    endfunction

    function automatic longint fx_abs(logic signed [31:0] v);
        longint w;
        w = longint'(v);
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic signed [31:0] fx_sub_sat(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        return fx_sat(longint'(a) - longint'(b));
    endfunction

    // Runs elimination with partial pivoting on the shadow matrix and queues
    // the node solutions.
    function automatic void solve_nodes();
        int n;
        int at;
        bit sing;
        logic signed [31:0] best;
        logic signed [31:0] t;
        logic signed [31:0] piv;
        out_item_t r;
        n = shadow_nodes;
        if (n < 2)
            n = 2;
        if (n > NMAX)
            n = NMAX;
        sing = 1'b0;
        for (int i = 1; i < n && !sing; i++)
        begin
            best = 0;
            at = i;
            for (int l = i; l < n; l++)
            begin
                if (fx_abs(shadow_mtx[l][i]) > fx_abs(best))
                begin
                    at = l;
                    best = shadow_mtx[l][i];
                end
            end
            if (at != i)
            begin
                for (int c = 1; c <= n; c++)
                begin
                    t = shadow_mtx[i][c];
                    shadow_mtx[i][c] = shadow_mtx[at][c];
                    shadow_mtx[at][c] = t;
                end
            end
            if (fx_abs(best) < longint'(shadow_tol))
                sing = 1'b1;
            else
            begin
                for (int j = n; j > 0; j--)
                begin
                    piv = fx_div(shadow_mtx[i][j], best);
                    shadow_mtx[i][j] = piv;
                    for (int l = 1; l < n; l++)
                        if (l != i)
                            shadow_mtx[l][j] = fx_sub_sat(shadow_mtx[l][j],
                                                          fx_mul(shadow_mtx[l][i], piv));
                end
            end
        end
        for (int i = 1; i < n; i++)
        begin
            r.node_number = i[3:0];
            r.node_value  = sing ? 32'sh0 : shadow_mtx[i][n];
            r.singular    = sing;
            r.last        = (i == n - 1);
            solution_q    = {solution_q, r};
        end
    endfunction

    // Applies one accepted request to the shadow state.
    function automatic void apply_request(in_item_t it);
        if (it.op == OP_WRITE)
        begin
            if (it.row_index >= 1 && it.column_index >= 1 && it.column_index <= NMAX)
            begin
                shadow_mtx[it.row_index][it.column_index] = it.entry_value;
                entry_written[it.row_index][it.column_index] = 1'b1;
            end
        end
        else
            solve_nodes();
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Sends one request; returns at the falling edge after it was accepted.
    task automatic send_request(in_item_t it);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do
            @(posedge clk);
        while (in_stall);
        apply_request(it);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_IDX_NODES)
            shadow_nodes = value[4:0];
        else
            shadow_tol = value[30:0];
    endtask

    // Waits until every queued solution has come out and the block settles.
    task automatic drain();
        in_valid = 1'b0;
        while (solution_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1: return 32'h0;
            2: return $urandom;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'h00000001;
                    default: return 32'hFFFFFFFF;
                endcase
            end
            default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
        endcase
    endfunction

    // Random entry writes, a fill of any unwritten entry the solve reads (column 1 with zeros
    // when zero_col is set), an occasional ignored write, then the solve request.
    task automatic solve_sequence(bit zero_col);
        in_item_t it;
        int n;
        n = shadow_nodes;
        if (n < 2)
            n = 2;
        if (n > NMAX)
            n = NMAX;
        repeat ($urandom_range(1, 4))
        begin
            it.op = OP_WRITE;
            it.row_index = 4'($urandom_range(1, n - 1));
            it.column_index = 5'($urandom_range(1, n));
            it.entry_value = pick_value();
            send_request(it);
        end
        for (int r = 1; r < n; r++)
            for (int c = 1; c <= n; c++)
                if (!entry_written[r][c] || (zero_col && c == 1))
                begin
                    it.op = OP_WRITE;
                    it.row_index = 4'(r);
                    it.column_index = 5'(c);
                    it.entry_value = zero_col && c == 1 ? 32'h0 : pick_value();
                    send_request(it);
                end
        if ($urandom_range(0, 3) == 0)
        begin
            it.op = OP_WRITE;
            it.row_index = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
            it.column_index = it.row_index == 0 ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(17, 31));
            it.entry_value = $urandom;
            send_request(it);
        end
        it.op = OP_SOLVE;
        it.row_index = 4'($urandom);
        it.column_index = 5'($urandom);
        it.entry_value = $urandom;
        send_request(it);
    endtask

    // Checks each accepted result against the oldest queued solution.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (solution_q.size() == 0)
            begin
                report("unexpected result for node", 32'(out_data.node_number), 32'd0);
            end
            else
            begin
                if (out_data.node_number != solution_q[0].node_number)
                    report("node_number", 32'(out_data.node_number),
                           32'(solution_q[0].node_number));
                if (out_data.node_value != solution_q[0].node_value)
                    report("node_value", out_data.node_value, solution_q[0].node_value);
                if (out_data.singular != solution_q[0].singular)
                    report("singular", 32'(out_data.singular),
                           32'(solution_q[0].singular));
                if (out_data.last != solution_q[0].last)
                    report("last", 32'(out_data.last), 32'(solution_q[0].last));
                void'(solution_q.pop_front());
            end
        end
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gauss_jordan_linear_solver_top regression: fail");
            $finish;
        end
    end

    // Receiver side: random stall bursts and one long hold-off while the
    // sender keeps offering requests.
    initial
    begin
        bit long_done;
        long_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_done && results_seen >= 12)
            begin
                long_done = 1'b1;
                out_stall = 1'b1;
                repeat (2000) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial
    begin
        dir_row_t dir_tbl[$];
        phase_t   phases[$];
        in_item_t it;
        int       before_cnt;
        int       nres;

        cycle_count  = 0;
        mismatches   = 0;
        results_seen = 0;
        quiet        = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        shadow_nodes = NODES_RESET;
        shadow_tol   = TOL_RESET;
        for (int r = 0; r < NMAX; r++)
            for (int c = 0; c < NCOL; c++)
            begin
                shadow_mtx[r][c] = 0;
                entry_written[r][c] = 1'b0;
            end

        // Directed table: all-zero singular solve, a plain system, ignored
        // writes outside the matrix, and extreme entries.
        dir_tbl = '{
            '{OP_WRITE, 1, 1, 32'h0, 0, 0, 0}, '{OP_WRITE, 1, 2, 32'h0, 0, 0, 0},
            '{OP_WRITE, 1, 3, 32'h0, 0, 0, 0}, '{OP_WRITE, 2, 1, 32'h0, 0, 0, 0},
            '{OP_WRITE, 2, 2, 32'h0, 0, 0, 0}, '{OP_WRITE, 2, 3, 32'h0, 0, 0, 0},
            '{OP_SOLVE, 0, 0, 32'h0, 1, 32'h0, 1},
            '{OP_WRITE, 1, 1, 32'h00020000, 0, 0, 0},
            '{OP_WRITE, 1, 3, 32'h00040000, 0, 0, 0},
            '{OP_WRITE, 2, 2, 32'h00010000, 0, 0, 0},
            '{OP_WRITE, 2, 3, 32'hFFFD0000, 0, 0, 0},
            '{OP_SOLVE, 15, 31, 32'hFFFFFFFF, 0, 0, 0},
            '{OP_WRITE, 0, 1, 32'h12345678, 0, 0, 0},
            '{OP_WRITE, 1, 0, 32'h12345678, 0, 0, 0},
            '{OP_WRITE, 1, 17, 32'h12345678, 0, 0, 0},
            '{OP_WRITE, 15, 31, 32'h12345678, 0, 0, 0},
            '{OP_WRITE, 1, 1, 32'h80000000, 0, 0, 0},
            '{OP_WRITE, 1, 2, 32'h7FFFFFFF, 0, 0, 0},
            '{OP_WRITE, 2, 1, 32'h7FFFFFFF, 0, 0, 0},
            '{OP_WRITE, 2, 2, 32'h00000001, 0, 0, 0},
            '{OP_WRITE, 1, 3, 32'h7FFFFFFF, 0, 0, 0},
            '{OP_WRITE, 2, 3, 32'h80000000, 0, 0, 0},
            '{OP_SOLVE, 0, 0, 32'h0, 0, 0, 0}
        };

        phases = '{
            '{5'd2, 31'd0, 5}, '{5'd4, 31'h7FFFFFFF, 3}, '{5'd5, 31'd1, 4},
            '{5'd0, 31'd1, 4}, '{5'd3, 31'h100, 5}, '{5'd1, 31'h8000, 3},
            '{5'd4, 31'd1, 4}, '{5'd5, 31'd1, 4}
        };

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(REG_IDX_NODES, 32'd3);
        write_reg(REG_IDX_TOL, 32'd1);
        foreach (dir_tbl[k])
        begin
            it.op           = dir_tbl[k].op;
            it.row_index    = dir_tbl[k].row;
            it.column_index = dir_tbl[k].col;
            it.entry_value  = dir_tbl[k].val;
            before_cnt = solution_q.size();
            send_request(it);
            // Rows with a typed answer override the predicted values.
            if (dir_tbl[k].typed)
            begin
                nres = solution_q.size() - before_cnt;
                for (int q = solution_q.size() - nres; q < solution_q.size(); q++)
                begin
                    solution_q[q].node_value = dir_tbl[k].typed_val;
                    solution_q[q].singular   = dir_tbl[k].typed_sing;
                end
            end
        end

        // Random phases, each under its own register setting.
        foreach (phases[p])
        begin
            drain();
            if (p == phases.size() - 1)
                quiet = 1'b1;
            write_reg(REG_IDX_NODES, {27'd0, phases[p].nodes});
            write_reg(REG_IDX_TOL, {1'b0, phases[p].tol});
            for (int s = 0; s < phases[p].seqs; s++)
                solve_sequence(phases[p].tol == 0 && s == 0);
        end

        in_valid = 1'b0;
        while (solution_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (mismatches == 0)
            $display("gauss_jordan_linear_solver_top regression: pass");
        else
            $display("gauss_jordan_linear_solver_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gjls_pkg.sv
rtl/core/gjls_ram.sv
rtl/core/gjls_div.sv
rtl/core/gjls_datapath.sv
rtl/core/gjls_ctrl.sv
rtl/core/gauss_jordan_linear_solver_top.sv
rtl/core/gjls_checker.sv
bench/tb_gauss_jordan_linear_solver_top.sv
